>>> src/assert_macros.svh
// Assertion macros shared by the atan2 unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/atsn_pkg.sv
// Shared constants and types of the self-normalizing atan2 unit.
`timescale 1ns / 1ps

package atsn_pkg;

    // Default operand width, angle fraction bits and queue depth
    localparam int IN_WIDTH_DEF    = 16;
    localparam int FRAC_BITS_DEF   = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result width is fixed
    localparam int OUT_WIDTH = 16;

    // Ratio is Q1.15: 15 fraction bits plus one integer bit of magnitude
    localparam int Q_FRAC = 15;
    localparam int Q_BITS = Q_FRAC + 1;

    // Degrees covered by one unit of the ratio
    localparam int ANGLE_UNIT = 45;

    // Classification of one request
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic num_neg;
        logic zero;
    } item_flags_t;

    localparam int FLAGS_W = $bits(item_flags_t);

endpackage

>>> src/atsn_channel_if.sv
// Valid/ready channel interfaces for operand requests and angle results.
`timescale 1ns / 1ps

interface atsn_in_if #(
    parameter int IN_WIDTH = atsn_pkg::IN_WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] x_value;
    logic signed [IN_WIDTH-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

interface atsn_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [atsn_pkg::OUT_WIDTH-1:0] angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

>>> src/atsn_front.sv
// Front end: accept operand requests and classify them into ratio terms.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atsn_front #(
    parameter int IN_WIDTH = atsn_pkg::IN_WIDTH_DEF,
    parameter int DW       = IN_WIDTH + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    atsn_in_if.sink               sample,
    output logic                  push_valid,
    input  logic                  push_ready,
    output atsn_pkg::item_flags_t flags,
    output logic [DW-1:0]         num_mag,
    output logic [DW-1:0]         den
);

    localparam int EW = IN_WIDTH + 2;

    logic signed [EW-1:0]  x_ext;
    logic signed [EW-1:0]  a_ext;
    logic signed [EW-1:0]  num_s;
    logic signed [EW-1:0]  den_s;
    logic signed [EW-1:0]  num_abs;
    logic                  accept;
    atsn_pkg::item_flags_t flags_next;

    logic                  valid_reg;
    atsn_pkg::item_flags_t flags_reg;
    logic [DW-1:0]         num_reg;
    logic [DW-1:0]         den_reg;

    // Form numerator and denominator of the ratio for the quadrant
    always_comb
    begin
        x_ext              = EW'(sample.x_value);
        flags_next.y_neg   = sample.y_value[IN_WIDTH-1];
        flags_next.x_neg   = sample.x_value[IN_WIDTH-1];
        a_ext              = flags_next.y_neg ? -EW'(sample.y_value) : EW'(sample.y_value);
        if (flags_next.x_neg)
        begin
            num_s = x_ext + a_ext;
            den_s = a_ext - x_ext;
        end
        else
        begin
            num_s = x_ext - a_ext;
            den_s = x_ext + a_ext;
        end
        flags_next.num_neg = num_s[EW-1];
        flags_next.zero    = (den_s == '0);
        num_abs            = num_s[EW-1] ? -num_s : num_s;
    end

    // Take a new request whenever the held one leaves or none is held
    assign sample.ready = !valid_reg || push_ready;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the classified request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
            num_reg   <= num_abs[DW-1:0];
            den_reg   <= den_s[DW-1:0];
        end
    end

    assign push_valid = valid_reg;
    assign flags      = flags_reg;
    assign num_mag    = num_reg;
    assign den        = den_reg;

    `ASSERT_NEXT(a_front_accept_held, accept, valid_reg, "accepted request not held")
    `ASSERT_SAME(a_front_num_le_den, valid_reg, num_reg <= den_reg, "ratio magnitude above one")

endmodule

>>> src/atsn_queue.sv
// Short FIFO between the classifying front end and the divider back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atsn_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = atsn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     head_next;
    logic [PW-1:0]     tail_reg;
    logic [PW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              push_en;
    logic              pop_en;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_en    = push_valid && push_ready;
    assign pop_en     = pop_valid && pop_ready;
    assign pop_data   = store_reg[head_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_en)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop_en)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            store_reg[tail_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_queue_fill_bound, count_reg <= CW'(DEPTH), "queue fill above depth")
    `ASSERT_SAME(a_queue_ptr_match, count_reg == '0, head_reg == tail_reg, "empty queue pointers differ")

endmodule

>>> src/atsn_back.sv
// Back end: pipelined ratio divider, angle scaling and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atsn_back #(
    parameter int IN_WIDTH  = atsn_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = atsn_pkg::FRAC_BITS_DEF,
    parameter int DW        = IN_WIDTH + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  atsn_pkg::item_flags_t flags,
    input  logic [DW-1:0]         num_mag,
    input  logic [DW-1:0]         den,
    atsn_out_if.source            result
);

    localparam int    NS     = atsn_pkg::Q_BITS;
    localparam int    QF     = atsn_pkg::Q_FRAC;
    localparam int    OW     = atsn_pkg::OUT_WIDTH;
    localparam int    Q_ONE  = 1 << QF;
    localparam int    K_INT  = atsn_pkg::ANGLE_UNIT << FRAC_BITS;
    localparam int    KW     = FRAC_BITS + 7;
    localparam int    PW     = KW + NS + 1;
    localparam int    AW     = KW + NS + 4;
    localparam int    GW     = AW - QF;
    localparam longint K_L   = longint'(K_INT);

    localparam logic signed [NS:0]   Q_MIN = (NS + 1)'(-Q_ONE);
    localparam logic signed [NS:0]   Q_MAX = (NS + 1)'(Q_ONE - 1);
    localparam logic signed [KW-1:0] K_S   = KW'(K_INT);
    localparam logic signed [AW-1:0] B_LO  = AW'(K_L << QF);
    localparam logic signed [AW-1:0] B_HI  = AW'((3 * K_L) << QF);
    localparam logic signed [AW-1:0] RND   = AW'(longint'(1) << (QF - 1));

    logic advance;

    // Divider stage inputs and next values
    logic                  src_valid [NS];
    logic [DW-1:0]         src_rem   [NS];
    logic [DW-1:0]         src_den   [NS];
    logic [NS-1:0]         src_quo   [NS];
    atsn_pkg::item_flags_t src_flags [NS];
    logic [DW:0]           trial     [NS];
    logic [DW:0]           diff      [NS];
    logic                  take      [NS];
    logic [DW-1:0]         div_rem_next [NS];
    logic [NS-1:0]         div_quo_next [NS];

    // Divider stage registers
    logic                  div_valid_reg [NS];
    logic [DW-1:0]         div_rem_reg   [NS];
    logic [DW-1:0]         div_den_reg   [NS];
    logic [NS-1:0]         div_quo_reg   [NS];
    atsn_pkg::item_flags_t div_flags_reg [NS];

    // Multiply stage
    logic [NS-1:0]         q_mag;
    logic signed [NS:0]    q_val;
    logic signed [PW-1:0]  m_prod_next;
    logic                  m_valid_reg;
    logic signed [PW-1:0]  m_prod_reg;
    atsn_pkg::item_flags_t m_flags_reg;

    // Output stage
    logic signed [AW-1:0]  acc;
    logic signed [GW-1:0]  ang_pos;
    logic signed [GW-1:0]  ang_next;
    logic                  out_valid_reg;
    logic signed [OW-1:0]  angle_reg;

    // Move the whole pipe whenever the output slot is free or drains
    assign advance   = !out_valid_reg || result.ready;
    assign pop_ready = advance;

    // Feed each divider stage from the queue or from the stage before it
    always_comb
    begin
        src_valid[0] = pop_valid;
        src_rem[0]   = num_mag;
        src_den[0]   = den;
        src_quo[0]   = '0;
        src_flags[0] = flags;
        for (int s = 1; s < NS; s++)
        begin
            src_valid[s] = div_valid_reg[s-1];
            src_rem[s]   = div_rem_reg[s-1];
            src_den[s]   = div_den_reg[s-1];
            src_quo[s]   = div_quo_reg[s-1];
            src_flags[s] = div_flags_reg[s-1];
        end
    end

    // Restoring division, one quotient bit per stage; the first stage
    // yields the integer bit without a shift
    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            trial[s]        = (s == 0) ? {1'b0, src_rem[s]} : {src_rem[s], 1'b0};
            take[s]         = (trial[s] >= {1'b0, src_den[s]});
            diff[s]         = trial[s] - {1'b0, src_den[s]};
            div_rem_next[s] = take[s] ? diff[s][DW-1:0] : trial[s][DW-1:0];
            div_quo_next[s] = {src_quo[s][NS-2:0], take[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                div_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                div_valid_reg[s] <= src_valid[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NS; s++)
            begin
                div_rem_reg[s]   <= div_rem_next[s];
                div_den_reg[s]   <= src_den[s];
                div_quo_reg[s]   <= div_quo_next[s];
                div_flags_reg[s] <= src_flags[s];
            end
        end
    end

    // Sign and saturate the Q1.15 ratio, then scale by 45 degrees
    always_comb
    begin
        q_mag = div_quo_reg[NS-1];
        priority if (div_flags_reg[NS-1].zero)
        begin
            q_val = Q_MIN;
        end
        else if (div_flags_reg[NS-1].num_neg)
        begin
            q_val = -$signed({1'b0, q_mag});
        end
        else if (q_mag == NS'(Q_ONE))
        begin
            q_val = Q_MAX;
        end
        else
        begin
            q_val = $signed({1'b0, q_mag});
        end
        m_prod_next = PW'(K_S) * PW'(q_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg   <= div_valid_reg[NS-1];
            out_valid_reg <= m_valid_reg;
        end
    end

    // Offset by the quadrant base, round, drop the ratio fraction, apply sign
    always_comb
    begin
        acc      = (m_flags_reg.x_neg ? B_HI : B_LO) - AW'(m_prod_reg) + RND;
        ang_pos  = acc[AW-1:QF];
        ang_next = m_flags_reg.y_neg ? -ang_pos : ang_pos;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_prod_reg  <= m_prod_next;
            m_flags_reg <= div_flags_reg[NS-1];
            angle_reg   <= ang_next[OW-1:0];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.angle_deg = angle_reg;

    // Zero over zero takes every trial subtraction, so its quotient is all ones
    `ASSERT_SAME(a_back_quo_bound, div_valid_reg[NS-1] && !div_flags_reg[NS-1].zero,
                 q_mag <= NS'(Q_ONE), "ratio above one")
    `ASSERT_SAME(a_back_zero_quo, div_valid_reg[NS-1] && div_flags_reg[NS-1].zero,
                 q_mag == {NS{1'b1}}, "zero pair quotient wrong")

endmodule

>>> src/atan2_self_normalizing_unit.sv
// Top level of the first-order self-normalizing atan2 approximation unit.
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    x_value, y_value (IN_WIDTH bits, signed)
//   result    out   valid/ready    angle_deg (16 bits, signed, 1/2^FRAC_BITS degree)
//
// One request per cycle sustained while results are taken; each result leaves
// after its request passes one classify register, one queue slot, 16 divider
// stages (one quotient bit each), one multiply stage and the output register.
// Every divider stage takes a new request each cycle while the back end
// advances, so the rate is one per cycle when the result side does not stall.
// Reset clears all valid bits and queue pointers; no clearing pass.
// A stalled result freezes the back end only; the front end and queue keep
// taking requests until the queue fills.
`timescale 1ns / 1ps

module atan2_self_normalizing_unit #(
    parameter int IN_WIDTH    = atsn_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS   = atsn_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = atsn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    atsn_in_if.sink     sample,
    atsn_out_if.source  result
);

    localparam int DW     = IN_WIDTH + 1;
    localparam int DATA_W = atsn_pkg::FLAGS_W + 2 * DW;

    logic                  f_valid;
    logic                  f_ready;
    atsn_pkg::item_flags_t f_flags;
    logic [DW-1:0]         f_num;
    logic [DW-1:0]         f_den;
    logic                  b_valid;
    logic                  b_ready;
    logic [DATA_W-1:0]     b_data;
    atsn_pkg::item_flags_t b_flags;
    logic [DW-1:0]         b_num;
    logic [DW-1:0]         b_den;

    // Classify requests
    atsn_front #(
        .IN_WIDTH (IN_WIDTH),
        .DW       (DW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .flags      (f_flags),
        .num_mag    (f_num),
        .den        (f_den)
    );

    // Decouple front and back
    atsn_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_flags, f_num, f_den}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign {b_flags, b_num, b_den} = b_data;

    // Divide and scale
    atsn_back #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .flags     (b_flags),
        .num_mag   (b_num),
        .den       (b_den),
        .result    (result)
    );

endmodule

>>> verif/atan2_self_normalizing_checker.sv
// Checker that predicts and compares the angles of the self-normalizing atan2 unit.
`timescale 1ns / 1ps

module atan2_self_normalizing_checker
    import atsn_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    atsn_in_if   sample,
    atsn_out_if  result,
    output int   errors,
    output int   pending,
    output int   requests_seen,
    output int   west_requests,
    output int   south_requests,
    output int   angles_checked
);

    localparam longint RATIO_ONE = longint'(1) << Q_FRAC;

    // One expected angle together with the request that caused it
    typedef struct packed {
        logic signed [IN_WIDTH-1:0]  x;
        logic signed [IN_WIDTH-1:0]  y;
        logic signed [OUT_WIDTH-1:0] angle;
    } angle_entry_t;

    angle_entry_t angle_fifo[$];

    // Compute the approximate angle in 1/2^FRAC_BITS degree for one operand pair
    function automatic logic signed [OUT_WIDTH-1:0] predict_angle(
        input logic signed [IN_WIDTH-1:0] xv,
        input logic signed [IN_WIDTH-1:0] yv
    );
        longint x_l;
        longint mag_y;
        longint num;
        longint den;
        longint ratio;
        longint unit;
        longint offset;
        longint acc;
        longint angle;
        x_l   = xv;
        mag_y = yv;
        if (mag_y < 0)
            mag_y = -mag_y;
        unit = longint'(ANGLE_UNIT) << FRAC_BITS;
        if (x_l >= 0)
        begin
            num    = x_l - mag_y;
            den    = x_l + mag_y;
            offset = unit;
        end
        else
        begin
            num    = x_l + mag_y;
            den    = mag_y - x_l;
            offset = 3 * unit;
        end
        // Zero over zero counts as a ratio of -1; otherwise truncate and saturate
        if (den == 0)
            ratio = -RATIO_ONE;
        else
        begin
            ratio = (num * RATIO_ONE) / den;
            if (ratio > RATIO_ONE - 1)
                ratio = RATIO_ONE - 1;
            if (ratio < -RATIO_ONE)
                ratio = -RATIO_ONE;
        end
        // Round the product term to nearest; the sum is always positive
        acc   = offset * RATIO_ONE - unit * ratio + RATIO_ONE / 2;
        angle = acc >>> Q_FRAC;
        if (yv < 0)
            angle = -angle;
        return angle[OUT_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    // Check each result, then queue the expectation of each new request
    always @(posedge clk)
    begin : watch
        angle_entry_t head;
        angle_entry_t entry;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                angles_checked++;
                if (angle_fifo.size() == 0)
                    report_mismatch($sformatf("angle %0d with no request outstanding",
                                              $signed(result.angle_deg)));
                else
                begin
                    head = angle_fifo.pop_front();
                    if (result.angle_deg !== head.angle)
                        report_mismatch($sformatf("x=%0d y=%0d: angle_deg %0d, want %0d",
                                                  head.x, head.y,
                                                  $signed(result.angle_deg), head.angle));
                end
            end
            if (sample.valid && sample.ready)
            begin
                entry.x     = sample.x_value;
                entry.y     = sample.y_value;
                entry.angle = predict_angle(sample.x_value, sample.y_value);
                angle_fifo.push_back(entry);
                requests_seen++;
                if (sample.x_value < 0)
                    west_requests++;
                if (sample.y_value < 0)
                    south_requests++;
            end
            pending <= angle_fifo.size();
        end
    end

endmodule

>>> verif/atan2_self_normalizing_unit_test.sv
// Testbench top: drives operand pairs into the atan2 unit and gives the verdict.
`timescale 1ns / 1ps

module atan2_self_normalizing_unit_test;
    import atsn_pkg::*;

    localparam int W           = IN_WIDTH_DEF;
    localparam int RANDOM_REQS = 1800;
    localparam int MAX_GAP     = 18;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_LIMIT  = 2000;

    logic clk;
    logic rst_n;

    int errors;
    int pending;
    int requests_seen;
    int west_requests;
    int south_requests;
    int angles_checked;
    int idle_cycles;
    bit send_burst;
    bit take_burst;

    atsn_in_if #(.IN_WIDTH(W)) sample_if ();
    atsn_out_if                result_if ();

    atan2_self_normalizing_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    atan2_self_normalizing_checker #(.IN_WIDTH(W)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample_if),
        .result         (result_if),
        .errors         (errors),
        .pending        (pending),
        .requests_seen  (requests_seen),
        .west_requests  (west_requests),
        .south_requests (south_requests),
        .angles_checked (angles_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draw the wait before the next handshake; bursts run with no gaps
    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Present one request and hold it until it is taken
    task automatic send_request(input logic signed [W-1:0] xv,
                                input logic signed [W-1:0] yv);
        int gap;
        gap = draw_gap(send_burst);
        if ($urandom_range(0, 31) == 0)
            send_burst = ~send_burst;
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.x_value <= xv;
        sample_if.y_value <= yv;
        do
            @(posedge clk);
        while (!sample_if.ready);
    endtask

    // Pick one operand: full range, small, or an extreme
    function automatic logic signed [W-1:0] draw_operand();
        case ($urandom_range(0, 5))
            0, 1, 2: return W'($urandom);
            3:       return W'($signed($urandom_range(0, 16)) - 8);
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       return W'(-(2 ** (W - 1)));
                    1:       return W'(-(2 ** (W - 1)) + 1);
                    2:       return W'(2 ** (W - 1) - 1);
                    default: return '0;
                endcase
            end
            default: return W'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Issue one random pair; some pairs sit on or near the diagonals and axes
    task automatic send_random_request();
        logic signed [W-1:0] xv;
        logic signed [W-1:0] yv;
        xv = draw_operand();
        yv = draw_operand();
        case ($urandom_range(0, 9))
            0:       yv = xv;
            1:       yv = -xv;
            2:       yv = xv + W'($signed($urandom_range(0, 2)) - 1);
            3:       yv = '0;
            4:       xv = '0;
            default: ;
        endcase
        send_request(xv, yv);
    endtask

    // Take results with random stalls
    initial
    begin : result_side
        int stall;
        result_if.ready <= 1'b0;
        take_burst = 1'b0;
        forever
        begin
            stall = draw_gap(take_burst);
            if ($urandom_range(0, 31) == 0)
                take_burst = ~take_burst;
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("atan2_self_normalizing_unit_test: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        sample_if.valid   <= 1'b0;
        sample_if.x_value <= '0;
        sample_if.y_value <= '0;
        send_burst = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both zero: ratio of -1, +90 degrees
        send_request(0, 0);
        // Ratio of +1 on the positive x axis saturates
        send_request(32767, 0);
        send_request(1, 0);
        // Negative x axis: 180 degrees
        send_request(-32768, 0);
        send_request(-1, 0);
        // Vertical axes, both signs, including the most negative y
        send_request(0, 32767);
        send_request(0, -32768);
        send_request(0, 1);
        send_request(0, -1);
        // Diagonals in all four quadrants
        send_request(32767, 32767);
        send_request(32767, -32768);
        send_request(-32768, 32767);
        send_request(-32768, -32768);
        send_request(-1, -1);
        send_request(1, -1);
        send_request(-1, 1);
        send_request(5, -5);
        send_request(-5, -5);
        // Near-axis and lopsided pairs
        send_request(-32768, 1);
        send_request(-32768, -1);
        send_request(1, -32768);
        send_request(-1, 32767);
        send_request(100, 3);
        send_request(-3, 100);

        repeat (RANDOM_REQS) send_random_request();
        sample_if.valid <= 1'b0;

        // Drain outstanding angles, then watch for strays
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests: %0d with x negative, %0d with y negative",
                 requests_seen, west_requests, south_requests);
        $display("checked %0d angles, %0d mismatches", angles_checked, errors);
        if (errors == 0)
            $display("atan2_self_normalizing_unit_test: clean");
        else
            $display("atan2_self_normalizing_unit_test: errors");
        $finish;
    end

endmodule

>>> atan2_self_normalizing_unit.f
+incdir+src
src/atsn_pkg.sv
src/atsn_channel_if.sv
src/atsn_front.sv
src/atsn_queue.sv
src/atsn_back.sv
src/atan2_self_normalizing_unit.sv
verif/atan2_self_normalizing_checker.sv
verif/atan2_self_normalizing_unit_test.sv
